// ===== rtl/core/cpf_pkg.sv =====
`default_nettype none
package cpf_pkg;

    // Fixed widths of the item fields.
    localparam int POS_W     = 25;
    localparam int TGT_W     = 18;
    localparam int DIM_W     = 16;
    localparam int SPEED_W   = 24;
    localparam int FT_W      = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Default fraction bits of the position.
    localparam int FRAC_BITS_DEF = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_SPD  = 3'd4;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_WARP  = 2'd1,
        KIND_SET   = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_STEP,
        S_SQRT,
        S_CHK,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_APPLY,
        S_FIN
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpf_if.sv =====
`default_nettype none

// Input item channel.
interface cpf_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic signed [cpf_pkg::TGT_W-1:0]  target_x;
    logic signed [cpf_pkg::TGT_W-1:0]  target_y;
    logic [cpf_pkg::FT_W-1:0]          frame_time;

    modport source (output valid, kind, target_x, target_y, frame_time, input ready);
    modport sink   (input valid, kind, target_x, target_y, frame_time, output ready);
endinterface

// Result item channel.
interface cpf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [cpf_pkg::POS_W-1:0]  pos_x;
    logic signed [cpf_pkg::POS_W-1:0]  pos_y;
    logic                              arrived;

    modport source (output valid, pos_x, pos_y, arrived, input ready);
    modport sink   (input valid, pos_x, pos_y, arrived, output ready);
endinterface

// Configuration write channel.
interface cpf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cpf_pkg::CFG_IDX_W-1:0]     index;
    logic [cpf_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/clamped_point_follower_core.sv =====
// Clamped point follower: keeps a view position (fixed point, FRAC_BITS
// fraction bits) on a map and moves it toward targets.
// Channels: in_item carries kind, target point and frame time; out_item
// returns one result per item (position and arrived flag); cfg writes the
// map size, view size and follow speed, always ready, and should only be
// written while the block is idle.
// Throughput: one item at a time; in_item is ready only while the
// sequencer is idle. Warp, set and clear go straight to the final state.
// A move squares both axis differences, forms the step, takes the square
// root and then, if the view really steps, runs two restoring divisions
// of SW = 16 + FRAC_BITS bits, one per axis. One shared multiplier serves
// all products; one square root step and one divide step per cycle.
// The result sits in an output register; a stalled receiver only holds
// the next item in its final state, and the block then waits.
// Reset clears the position, the configuration registers and the
// sequencer and output handshake state; datapath registers are not reset.
`default_nettype none
module clamped_point_follower_core #(
    parameter int FRAC_BITS = cpf_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpf_in_if.sink    in_item,
    cpf_out_if.source out_item,
    cpf_cfg_if.sink   cfg
);
    import cpf_pkg::*;

    // Datapath widths.
    localparam int DW  = POS_W + 1;                 // axis difference / magnitude
    localparam int SW  = SPEED_W + FT_W + FRAC_BITS - 18; // step width
    localparam int BW  = (SW > DW) ? SW : DW;       // multiplier operand B
    localparam int PW  = DW + BW;                   // product width
    localparam int QW  = 2 * DW;                    // radicand width
    localparam int RW  = DW + 2;                    // remainder width
    localparam int CW  = $clog2(BW + 1);
    localparam int PRW = TGT_W + 1;                 // clamp input width

    // Clamp one axis and scale to fixed point, wrapping to the position width.
    function automatic logic [POS_W-1:0] clamp_axis(
        input logic signed [PRW-1:0] p,
        input logic [DIM_W-1:0]      map_sz,
        input logic [DIM_W-1:0]      view_sz
    );
        logic signed [PRW-1:0]   hi;
        logic signed [PRW-1:0]   c;
        logic signed [POS_W-1:0] ce;
        begin
            hi = $signed(PRW'({1'b0, map_sz})) - $signed(PRW'({1'b0, view_sz}));
            c  = (p < 0) ? '0 : p;
            if (c > hi)
                c = hi;
            ce = POS_W'(c);
            clamp_axis = {ce[POS_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]   map_w_reg, map_h_reg, view_w_reg, view_h_reg;
    logic [SPEED_W-1:0] speed_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg  <= '0;
            map_h_reg  <= '0;
            view_w_reg <= '0;
            view_h_reg <= '0;
            speed_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAP_WIDTH:   map_w_reg  <= cfg.data[DIM_W-1:0];
                REG_MAP_HEIGHT:  map_h_reg  <= cfg.data[DIM_W-1:0];
                REG_VIEW_WIDTH:  view_w_reg <= cfg.data[DIM_W-1:0];
                REG_VIEW_HEIGHT: view_h_reg <= cfg.data[DIM_W-1:0];
                REG_FOLLOW_SPD:  speed_reg  <= cfg.data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // State and datapath registers.
    state_t state_reg, state_next;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [POS_W-1:0]        cx_reg, cy_reg, rx_reg, ry_reg;
    logic [FT_W-1:0]         ft_reg;
    logic [DW-1:0]           ax_reg, ay_reg;
    logic                    nx_reg, ny_reg;
    logic [PW-1:0]           prod_reg;
    logic [QW-1:0]           acc_reg;
    logic [RW-1:0]           rem_reg;
    logic [DW-1:0]           root_reg;
    logic [SW-1:0]           step_reg;
    logic [SW-1:0]           num_reg;
    logic [SW-1:0]           quo_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    axis_reg;
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_x_reg, out_y_reg;
    logic                    out_arr_reg;

    // Clamped points for the incoming item.
    logic signed [PRW-1:0] px_c, py_c, px_t, py_t;
    logic [POS_W-1:0]      cx_c, cy_c, sx_c, sy_c;
    logic signed [DW-1:0]  dx_c, dy_c;

    always_comb
    begin
        px_t = PRW'(in_item.target_x);
        py_t = PRW'(in_item.target_y);
        px_c = px_t - $signed(PRW'(view_w_reg[DIM_W-1:1]));
        py_c = py_t - $signed(PRW'(view_h_reg[DIM_W-1:1]));
        cx_c = clamp_axis(px_c, map_w_reg, view_w_reg);
        cy_c = clamp_axis(py_c, map_h_reg, view_h_reg);
        sx_c = clamp_axis(px_t, map_w_reg, view_w_reg);
        sy_c = clamp_axis(py_t, map_h_reg, view_h_reg);
        dx_c = DW'($signed(cx_c)) - DW'(pos_x_reg);
        dy_c = DW'($signed(cy_c)) - DW'(pos_y_reg);
    end

    // Shared multiplier.
    logic [DW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;

    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = BW'(ax_reg);
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = BW'(ay_reg);
            end
            S_STEP:
            begin
                mul_a = DW'(ft_reg);
                mul_b = BW'(speed_reg);
            end
            default:
            begin
                mul_a = axis_reg ? ay_reg : ax_reg;
                mul_b = BW'(step_reg);
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Square root and divide steps.
    logic [RW-1:0]           sq_rem, sq_trial;
    logic [DW:0]             dv_trial;
    logic [FT_W+SPEED_W+FRAC_BITS-1:0] step_full;
    logic [BW-1:0]           q_ext;
    logic [POS_W-1:0]        q_mag, q_add;
    logic                    sq_last, dv_last;

    always_comb
    begin
        sq_rem    = {rem_reg[RW-3:0], acc_reg[QW-1:QW-2]};
        sq_trial  = {root_reg, 2'b01};
        dv_trial  = {rem_reg[DW-1:0], num_reg[SW-1]};
        step_full = {prod_reg[FT_W+SPEED_W-1:0], {FRAC_BITS{1'b0}}};
        q_ext     = BW'(quo_reg);
        q_mag     = q_ext[POS_W-1:0];
        q_add     = (axis_reg ? ny_reg : nx_reg) ? (~q_mag + 1'b1) : q_mag;
        sq_last   = (cnt_reg == CW'(DW - 1));
        dv_last   = (cnt_reg == CW'(SW - 1));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_item.valid)
                    state_next = (kind_t'(in_item.kind) == KIND_MOVE) ? S_SQX : S_FIN;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_STEP;
            S_STEP:  state_next = S_SQRT;
            S_SQRT:  if (sq_last) state_next = S_CHK;
            S_CHK:
                if (root_reg == '0 || DW'(root_reg) <= DW'(step_reg) && SW <= DW
                    || BW'(root_reg) <= BW'(step_reg))
                    state_next = S_FIN;
                else
                    state_next = S_MUL;
            S_MUL:   state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:   if (dv_last) state_next = S_APPLY;
            S_APPLY: state_next = axis_reg ? S_FIN : S_MUL;
            S_FIN:   if (!out_valid_reg || out_item.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_item.ready = (state_reg == S_IDLE);
    end

    assign out_item.valid   = out_valid_reg;
    assign out_item.pos_x   = out_x_reg;
    assign out_item.pos_y   = out_y_reg;
    assign out_item.arrived = out_arr_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && (!out_valid_reg || out_item.ready))
                out_valid_reg <= 1'b1;
            else if (out_item.ready)
                out_valid_reg <= 1'b0;

            // Position updates.
            if (state_reg == S_IDLE && in_item.valid)
            begin
                case (kind_t'(in_item.kind))
                    KIND_WARP:
                    begin
                        pos_x_reg <= $signed(cx_c);
                        pos_y_reg <= $signed(cy_c);
                    end
                    KIND_SET:
                    begin
                        pos_x_reg <= $signed(sx_c);
                        pos_y_reg <= $signed(sy_c);
                    end
                    KIND_CLEAR:
                    begin
                        pos_x_reg <= '0;
                        pos_y_reg <= '0;
                    end
                    default: ;
                endcase
            end
            else if (state_reg == S_CHK && root_reg != '0 && state_next == S_FIN)
            begin
                pos_x_reg <= $signed(cx_reg);
                pos_y_reg <= $signed(cy_reg);
            end
            else if (state_reg == S_APPLY)
            begin
                if (axis_reg)
                    pos_y_reg <= pos_y_reg + $signed(q_add);
                else
                    pos_x_reg <= pos_x_reg + $signed(q_add);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cx_reg   <= cx_c;
                cy_reg   <= cy_c;
                rx_reg   <= (kind_t'(in_item.kind) == KIND_SET) ? sx_c : cx_c;
                ry_reg   <= (kind_t'(in_item.kind) == KIND_SET) ? sy_c : cy_c;
                ft_reg   <= in_item.frame_time;
                nx_reg   <= dx_c[DW-1];
                ny_reg   <= dy_c[DW-1];
                ax_reg   <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
                ay_reg   <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
                axis_reg <= 1'b0;
            end
            S_SQX:
                prod_reg <= mul_p;
            S_SQY:
            begin
                acc_reg  <= QW'(prod_reg);
                prod_reg <= mul_p;
            end
            S_STEP:
            begin
                acc_reg  <= acc_reg + QW'(prod_reg);
                prod_reg <= mul_p;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_SQRT:
            begin
                step_reg <= step_full[FT_W+SPEED_W+FRAC_BITS-1:18];
                acc_reg  <= {acc_reg[QW-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 1'b1;
                if (sq_rem >= sq_trial)
                begin
                    rem_reg  <= sq_rem - sq_trial;
                    root_reg <= {root_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_rem;
                    root_reg <= {root_reg[DW-2:0], 1'b0};
                end
            end
            S_MUL:
                prod_reg <= mul_p;
            S_DINIT:
            begin
                rem_reg <= RW'(prod_reg[SW+DW-1:SW]);
                num_reg <= prod_reg[SW-1:0];
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                num_reg <= {num_reg[SW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (dv_trial >= {1'b0, root_reg})
                begin
                    rem_reg <= RW'(dv_trial - {1'b0, root_reg});
                    quo_reg <= {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= RW'(dv_trial);
                    quo_reg <= {quo_reg[SW-2:0], 1'b0};
                end
            end
            S_APPLY:
                axis_reg <= 1'b1;
            S_FIN:
                if (!out_valid_reg || out_item.ready)
                begin
                    out_x_reg   <= pos_x_reg;
                    out_y_reg   <= pos_y_reg;
                    out_arr_reg <= (pos_x_reg == $signed(rx_reg))
                                   && (pos_y_reg == $signed(ry_reg));
                end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
